FILE: rtl/core/bne_pkg.sv
// Package for the boolean netlist evaluator: wire store sizing, item codes
// and the structs passed between the execute stage and the wire memory.
// Depends on nothing; the interfaces, wire memory, execute stage and top level use it.
`default_nettype none

package bne_pkg;

  // Wire store geometry. Wire indexes are 16-bit fields, so the store covers
  // every index that an item can name.
  localparam int unsigned WireIdxW  = 16;
  localparam int unsigned WireCount = 1 << WireIdxW;

  typedef logic [WireIdxW-1:0] wire_idx_t;

  // Action code 3 is unused and falls to the default arm wherever decoded.
  typedef enum logic [1:0] {
    ActLoad = 2'd0,
    ActGate = 2'd1,
    ActRead = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KindAnd = 2'd0,
    KindOr  = 2'd1,
    KindXor = 2'd2,
    KindInv = 2'd3
  } gate_kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] gate_kind;
    wire_idx_t  first_wire;
    wire_idx_t  second_wire;
    wire_idx_t  dest_wire;
    logic       load_value;
  } item_t;

  // One write into the wire memory.
  typedef struct packed {
    logic      en;
    wire_idx_t addr;
    logic      data;
  } wr_t;

endpackage : bne_pkg

`default_nettype wire

FILE: rtl/core/bne_if.sv
// Valid/ready channel interfaces for the boolean netlist evaluator.
// Depends on bne_pkg for the wire index type.
`default_nettype none

interface bne_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [1:0]          gate_kind;
  bne_pkg::wire_idx_t  first_wire;
  bne_pkg::wire_idx_t  second_wire;
  bne_pkg::wire_idx_t  dest_wire;
  logic                load_value;

  modport source (
    output valid, action, gate_kind, first_wire, second_wire, dest_wire, load_value,
    input  ready
  );
  modport sink (
    input  valid, action, gate_kind, first_wire, second_wire, dest_wire, load_value,
    output ready
  );
endinterface : bne_in_if

interface bne_out_if;
  logic valid;
  logic ready;
  logic wire_value;

  modport source (output valid, wire_value, input ready);
  modport sink (input valid, wire_value, output ready);
endinterface : bne_out_if

`default_nettype wire

FILE: rtl/core/bne_wire_ram.sv
// Wire value memory: one bit per wire, two registered read ports and one
// write port. Depends on bne_pkg for geometry and the write struct.
`default_nettype none

module bne_wire_ram (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  bne_pkg::wire_idx_t rd_addr_a_i,
  input  bne_pkg::wire_idx_t rd_addr_b_i,
  output logic               rd_data_a_o,
  output logic               rd_data_b_o,
  input  bne_pkg::wr_t       wr_i
);

  logic mem [bne_pkg::WireCount];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read before write: a read at the same edge as a write to the same wire
  // returns the old bit; the execute stage forwards around that case.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule : bne_wire_ram

`default_nettype wire

FILE: rtl/core/bne_exec.sv
// Execute stage: holds the item whose source bits are being read, applies
// the gate, writes the result back and feeds the output register.
// Depends on bne_pkg for the item and write structs and the codes.
`default_nettype none

module bne_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bne_pkg::item_t     item_i,
  output logic               in_ready_o,
  input  logic               rd_data_a_i,
  input  logic               rd_data_b_i,
  output bne_pkg::wr_t       wr_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               wire_value_o
);

  logic           s1_valid_q, s1_valid_d;
  bne_pkg::item_t s1_item_q;
  logic           fwd_a_q, fwd_a_d;
  logic           fwd_b_q, fwd_b_d;
  logic           fwd_bit_q;
  logic           out_valid_q, out_valid_d;
  logic           out_value_q;

  logic in_acc;
  logic advance;
  logic src_a, src_b;
  logic result;
  logic writes;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  // The memory read for the new item happens at the same edge as this
  // item's write, so a match on the destination is bypassed.
  assign src_a = fwd_a_q ? fwd_bit_q : rd_data_a_i;
  assign src_b = fwd_b_q ? fwd_bit_q : rd_data_b_i;

  always_comb begin
    result = 1'b0;
    writes = 1'b0;
    unique case (bne_pkg::action_e'(s1_item_q.action))
      bne_pkg::ActLoad: begin
        result = s1_item_q.load_value;
        writes = 1'b1;
      end
      bne_pkg::ActGate: begin
        writes = 1'b1;
        unique case (bne_pkg::gate_kind_e'(s1_item_q.gate_kind))
          bne_pkg::KindAnd: result = src_a & src_b;
          bne_pkg::KindOr:  result = src_a | src_b;
          bne_pkg::KindXor: result = src_a ^ src_b;
          bne_pkg::KindInv: result = ~src_a;
          default:          result = 1'b0;
        endcase
      end
      bne_pkg::ActRead: result = src_a;
      default:          result = 1'b0;
    endcase
  end

  assign wr_o.en   = advance && writes;
  assign wr_o.addr = s1_item_q.dest_wire;
  assign wr_o.data = result;

  always_comb begin
    s1_valid_d  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    fwd_a_d     = in_acc && wr_o.en && (item_i.first_wire == wr_o.addr);
    fwd_b_d     = in_acc && wr_o.en && (item_i.second_wire == wr_o.addr);
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= item_i;
      fwd_a_q   <= fwd_a_d;
      fwd_b_q   <= fwd_b_d;
      fwd_bit_q <= wr_o.data;
    end
    if (advance) begin
      out_value_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wire_value_o = out_value_q;

endmodule : bne_exec

`default_nettype wire

FILE: rtl/core/boolean_netlist_evaluator.sv
// Top level of the boolean netlist evaluator: wire memory plus execute stage.
// Depends on bne_pkg, bne_if, bne_wire_ram and bne_exec.
//
//   Channel | Direction | Word carries
//   --------+-----------+-------------------------------------------------
//   in_i    | sink      | action, gate_kind, first/second/dest wire, load bit
//   out_o   | source    | wire_value, one word per accepted input word
//
// One word is taken per cycle, sustained, while the output is not held. The
// accepting edge also registers both source bits out of the wire memory;
// during the next cycle the execute stage applies the gate, and at the edge
// at which it advances it writes the result back and loads the output
// register. A result word is thus offered after the execute stage register
// and the output register. A gate that uses the wire written by the word
// just before it gets the bit through a forwarding path.
// Reset clears only the control flags; the wire memory is not cleared and a
// wire must be written before it is read. A stalled output holds the execute
// stage, and input ready drops only while both stages are full.
`default_nettype none

module boolean_netlist_evaluator (
  input  logic clk_i,
  input  logic rst_ni,
  bne_in_if.sink    in_i,
  bne_out_if.source out_o
);

  bne_pkg::item_t item;
  bne_pkg::wr_t   wr;
  logic           rd_data_a;
  logic           rd_data_b;
  logic           in_acc;

  // Gather the input word into one struct for the execute stage.
  assign item.action      = in_i.action;
  assign item.gate_kind   = in_i.gate_kind;
  assign item.first_wire  = in_i.first_wire;
  assign item.second_wire = in_i.second_wire;
  assign item.dest_wire   = in_i.dest_wire;
  assign item.load_value  = in_i.load_value;

  // Source wires are read only when a word is accepted, so the read data
  // stays put while the execute stage is stalled.
  assign in_acc = in_i.valid && in_i.ready;

  bne_wire_ram u_ram (
    .clk_i       (clk_i),
    .rd_en_i     (in_acc),
    .rd_addr_a_i (in_i.first_wire),
    .rd_addr_b_i (in_i.second_wire),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b),
    .wr_i        (wr)
  );

  bne_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .item_i       (item),
    .in_ready_o   (in_i.ready),
    .rd_data_a_i  (rd_data_a),
    .rd_data_b_i  (rd_data_b),
    .wr_o         (wr),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .wire_value_o (out_o.wire_value)
  );

endmodule : boolean_netlist_evaluator

`default_nettype wire

FILE: rtl/core/bne_checker.sv
// Port-level checks for the boolean netlist evaluator, bound to the top level.
// Depends only on the top level's port signals.
`default_nettype none

module bne_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A result word waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // The input side stalls only when both stages are full and the output is
  // being held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without an output stall");

  // A fresh result passes the execute stage register and then the output
  // register after its word was taken; each rise of valid has a word behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word appeared with no input word behind it");

endmodule : bne_checker

bind boolean_netlist_evaluator bne_checker u_bne_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

`default_nettype wire
